// ===== design/skt_pkg.sv =====
// Shared operation codes, status codes and cell control types for the sorted key table.
package skt_pkg;

    localparam int KEY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int TOTAL_W  = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Per-cell comparison result against the request key.
    typedef struct packed {
        logic lt;   // occupied and stored key is smaller than the request key
        logic eq;   // occupied and stored key equals the request key
    } skt_flag_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic                    load;   // compare and capture flags
        logic                    shift;  // move scan flags one cell toward the head
        logic                    ins;    // open a gap and write the request key
        logic                    del;    // close the gap over the first equal key
        logic signed [KEY_W-1:0] key;
    } skt_cmd_t;

endpackage

// ===== design/skt_cell.sv =====
// One storage cell of the sorted key chain: a key, its comparison flags and a scan stage.
module skt_cell (
    input  logic                          clk,
    input  skt_pkg::skt_cmd_t             cmd,
    input  logic                          occupied,
    input  logic                          prev_lt,
    input  logic signed [skt_pkg::KEY_W-1:0] prev_key,
    input  logic signed [skt_pkg::KEY_W-1:0] next_key,
    input  skt_pkg::skt_flag_t            next_scan,
    output logic signed [skt_pkg::KEY_W-1:0] key,
    output logic                          lt,
    output skt_pkg::skt_flag_t            scan
);
    import skt_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    skt_flag_t               flag_reg;
    skt_flag_t               flag_next;
    skt_flag_t               scan_reg;
    skt_flag_t               scan_next;

    always_comb
    begin
        flag_next = flag_reg;
        scan_next = scan_reg;
        key_next  = key_reg;
        if (cmd.load)
        begin
            flag_next.lt = occupied && (key_reg < cmd.key);
            flag_next.eq = occupied && (key_reg == cmd.key);
            scan_next    = flag_next;
        end
        else if (cmd.shift)
        begin
            scan_next = next_scan;
        end
        // Cells holding smaller keys keep them; the rest move by one place.
        if (cmd.ins && !flag_reg.lt)
        begin
            key_next = prev_lt ? cmd.key : prev_key;
        end
        else if (cmd.del && !flag_reg.lt)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        flag_reg <= flag_next;
        scan_reg <= scan_next;
    end

    assign key  = key_reg;
    assign lt   = flag_reg.lt;
    assign scan = scan_reg;

endmodule

// ===== design/sorted_key_table.sv =====
// Top level of the sorted key table: a chain of compare-and-shift cells and its controller.
//
//   Channel   Direction  Handshake                Payload
//   request   in         start high, busy low     mode, key
//   result    out        done strobe, one cycle   status, position, entry_total
//
// A request is taken at the edge where start is high and busy is low. At that edge
// every cell compares its key with the request key and stores the outcome. The
// controller then scans the "smaller" flags, which shift one cell per cycle toward
// cell 0. The scan passes every stored key smaller than the request key and stops at
// the first flag that is not set; the done word is registered at the edge that ends
// the scan, as busy falls. Inserts and deletes move every affected cell in the
// single cycle that ends the scan.
// Reset clears the entry count and the controller; keys in the cells stay as they are
// and are never read above the count. The receiver cannot stall: done is high for
// exactly one cycle and the word must be taken then.
module sorted_key_table #(
    parameter int CAPACITY = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [skt_pkg::MODE_W-1:0]         mode,
    input  logic signed [skt_pkg::KEY_W-1:0]   key,
    output logic                               done,
    output logic [skt_pkg::STATUS_W-1:0]       status,
    output logic [skt_pkg::POS_W-1:0]          position,
    output logic [skt_pkg::TOTAL_W-1:0]        entry_total
);
    import skt_pkg::*;

    // The count and the scan index both reach CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           cnt_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic                    done_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [CW-1:0]           pos_reg;

    skt_cmd_t                cmd;
    logic                    finish;
    logic                    found;
    logic                    room;
    logic [STATUS_W-1:0]     status_next;
    logic [CW-1:0]           count_next;

    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]     cell_lt;
    logic [CAPACITY-1:0]     occ;
    skt_flag_t               cell_scan [CAPACITY];

    // The head cell shows the flag pair at the current scan index.
    assign finish = (state_reg == SCAN) && !cell_scan[0].lt;
    assign found  = cell_scan[0].eq;
    assign room   = (count_reg != CW'(CAPACITY));

    always_comb
    begin
        cmd.load  = (state_reg == IDLE) && start;
        cmd.shift = (state_reg == SCAN) && cell_scan[0].lt;
        cmd.ins   = finish && (mode_reg == MODE_INSERT) && room;
        cmd.del   = finish && (mode_reg == MODE_DELETE) && found;
        cmd.key   = (state_reg == IDLE) ? key : key_reg;
    end

    always_comb
    begin
        status_next = ST_ABSENT;
        count_next  = count_reg;
        case (mode_reg)
            MODE_INSERT:
            begin
                if (room)
                begin
                    status_next = ST_DONE;
                    count_next  = count_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            MODE_FIND:
            begin
                if (found)
                begin
                    status_next = ST_DONE;
                end
            end
            MODE_DELETE:
            begin
                if (found)
                begin
                    status_next = ST_DONE;
                    count_next  = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_ABSENT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    if (finish)
                    begin
                        state_reg <= IDLE;
                        done_reg  <= 1'b1;
                        count_reg <= count_next;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            cnt_reg  <= '0;
        end
        else if (cmd.shift)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (finish)
        begin
            status_reg <= status_next;
            pos_reg    <= (status_next == ST_DONE) ? cnt_reg : '0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign occ[gi] = (count_reg > CW'(gi));

            if (gi == 0)
            begin : g_head
                skt_cell u_cell (
                    .clk       (clk),
                    .cmd       (cmd),
                    .occupied  (occ[gi]),
                    .prev_lt   (1'b1),
                    .prev_key  (cmd.key),
                    .next_key  (cell_key[(gi + 1) % CAPACITY]),
                    .next_scan (cell_scan[(gi + 1) % CAPACITY]),
                    .key       (cell_key[gi]),
                    .lt        (cell_lt[gi]),
                    .scan      (cell_scan[gi])
                );
            end
            else if (gi == CAPACITY - 1)
            begin : g_tail
                skt_cell u_cell (
                    .clk       (clk),
                    .cmd       (cmd),
                    .occupied  (occ[gi]),
                    .prev_lt   (cell_lt[gi - 1]),
                    .prev_key  (cell_key[gi - 1]),
                    .next_key  (cell_key[gi]),
                    .next_scan ('0),
                    .key       (cell_key[gi]),
                    .lt        (cell_lt[gi]),
                    .scan      (cell_scan[gi])
                );
            end
            else
            begin : g_mid
                skt_cell u_cell (
                    .clk       (clk),
                    .cmd       (cmd),
                    .occupied  (occ[gi]),
                    .prev_lt   (cell_lt[gi - 1]),
                    .prev_key  (cell_key[gi - 1]),
                    .next_key  (cell_key[gi + 1]),
                    .next_scan (cell_scan[gi + 1]),
                    .key       (cell_key[gi]),
                    .lt        (cell_lt[gi]),
                    .scan      (cell_scan[gi])
                );
            end
        end
    endgenerate

    // Fit the internal index and count to the result word's field widths.
    logic [CW+POS_W-1:0]   pos_ext;
    logic [CW+TOTAL_W-1:0] total_ext;

    assign pos_ext   = {{POS_W{1'b0}}, pos_reg};
    assign total_ext = {{TOTAL_W{1'b0}}, count_reg};

    assign busy        = (state_reg != IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = pos_ext[POS_W-1:0];
    assign entry_total = total_ext[TOTAL_W-1:0];

endmodule

// ===== design/skt_checker.sv =====
// Port-level checks for the sorted key table, bound to the top level.
module skt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [skt_pkg::STATUS_W-1:0] status,
    input logic [skt_pkg::POS_W-1:0]    position,
    input logic [skt_pkg::TOTAL_W-1:0]  entry_total
);
    import skt_pkg::*;

    // An accepted request always makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // A result word only closes a request that was in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe without a request in progress");

    // A failed request reports position zero.
    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_DONE |-> position == '0)
        else $error("failed request reported a nonzero position");

    // The total changes only with a completed result.
    a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(entry_total))
        else $error("entry total changed without a result");

    // A successful request never places a key beyond the stored total. A delete of
    // the last key reports a position equal to the new total.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_DONE && entry_total != '0 |->
            {1'b0, position} <= entry_total || entry_total[TOTAL_W-1])
        else $error("position beyond the entry total");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .position    (position),
    .entry_total (entry_total)
);

// ===== tb/sorted_key_table_tb.sv =====
// Self-checking testbench for the sorted key table: directed table, random phases, predictor.
`timescale 1ns / 100ps

module sorted_key_table_tb;

    import skt_pkg::*;

    localparam int CAPACITY = 64;

    // Mode code 3 has no operation behind it; the block must answer "not found" and
    // leave the table alone.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    // A request can sit behind a busy block for a whole scan of the table and the sender
    // may add an idle gap, so a run of STALL_LIMIT silent cycles means a hang.
    localparam int STALL_LIMIT = 4000;

    // One result word as it appears on the result ports.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [TOTAL_W-1:0]  entry_total;
    } table_word_t;

    // One line of the directed table. A row with typed set carries the word that the
    // block must return; every other row is checked against the predictor. A row with
    // a repeat count above one is sent that many times.
    typedef struct {
        logic [MODE_W-1:0]        op;
        logic signed [KEY_W-1:0]  k;
        int                       reps;
        bit                       typed;
        table_word_t              word;
    } request_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [MODE_W-1:0]         mode = MODE_INSERT;
    logic signed [KEY_W-1:0]   key = '0;
    logic                      busy;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          position;
    logic [TOTAL_W-1:0]        entry_total;

    // The typed expectation travels with the request and is driven at the same edge,
    // so the checker sees the one that belongs to the word being accepted.
    bit                        typed_valid = 1'b0;
    table_word_t               typed_word = '0;

    // Predictor state: the keys the block should hold, in ascending order.
    logic signed [KEY_W-1:0]   held_keys[$];
    table_word_t               expected_words[$];

    int                        fail_count = 0;
    int                        stall_cycles = 0;
    bit                        idling_on = 1'b1;

    request_row_t directed_rows [0:24] = '{
        // Empty table: every lookup misses, the unused mode answers "not found".
        '{MODE_FIND,   32'sd0,        1, 1'b1, '{ST_ABSENT, 6'd0,  7'd0}},
        '{MODE_DELETE, 32'sd5,        1, 1'b1, '{ST_ABSENT, 6'd0,  7'd0}},
        '{MODE_UNUSED, -32'sd1,       1, 1'b1, '{ST_ABSENT, 6'd0,  7'd0}},
        // Extremes of the key range, then a duplicate that must land ahead of its twin.
        '{MODE_INSERT, KEY_MAX,       1, 1'b1, '{ST_DONE,   6'd0,  7'd1}},
        '{MODE_INSERT, KEY_MIN,       1, 1'b1, '{ST_DONE,   6'd0,  7'd2}},
        '{MODE_INSERT, 32'sd0,        1, 1'b1, '{ST_DONE,   6'd1,  7'd3}},
        '{MODE_INSERT, 32'sd0,        1, 1'b1, '{ST_DONE,   6'd1,  7'd4}},
        '{MODE_FIND,   32'sd0,        1, 1'b1, '{ST_DONE,   6'd1,  7'd4}},
        '{MODE_FIND,   KEY_MAX,       1, 1'b1, '{ST_DONE,   6'd3,  7'd4}},
        '{MODE_FIND,   KEY_MIN,       1, 1'b1, '{ST_DONE,   6'd0,  7'd4}},
        '{MODE_FIND,   32'sd1,        1, 1'b1, '{ST_ABSENT, 6'd0,  7'd4}},
        '{MODE_DELETE, 32'sd0,        1, 1'b1, '{ST_DONE,   6'd1,  7'd3}},
        '{MODE_DELETE, KEY_MIN,       1, 1'b1, '{ST_DONE,   6'd0,  7'd2}},
        '{MODE_DELETE, KEY_MIN,       1, 1'b1, '{ST_ABSENT, 6'd0,  7'd2}},
        '{MODE_UNUSED, KEY_MAX,       1, 1'b1, '{ST_ABSENT, 6'd0,  7'd2}},
        // Fill the table to capacity with one repeated key.
        '{MODE_INSERT, -32'sd1,      62, 1'b0, '0},
        // A full table refuses inserts and keeps its count.
        '{MODE_INSERT, KEY_MAX,       1, 1'b1, '{ST_FULL,   6'd0,  7'd64}},
        '{MODE_INSERT, KEY_MIN,       1, 1'b1, '{ST_FULL,   6'd0,  7'd64}},
        // The last slot: find, delete and refill it.
        '{MODE_FIND,   KEY_MAX,       1, 1'b1, '{ST_DONE,   6'd63, 7'd64}},
        '{MODE_DELETE, KEY_MAX,       1, 1'b1, '{ST_DONE,   6'd63, 7'd63}},
        '{MODE_INSERT, KEY_MAX - 1,   1, 1'b1, '{ST_DONE,   6'd63, 7'd64}},
        // Remove most of the duplicates again.
        '{MODE_DELETE, -32'sd1,      40, 1'b0, '0},
        '{MODE_UNUSED, 32'sd0,        1, 1'b1, '{ST_ABSENT, 6'd0,  7'd24}},
        '{MODE_FIND,   32'sd0,        1, 1'b1, '{ST_DONE,   6'd22, 7'd24}},
        '{MODE_DELETE, 32'sd0,        1, 1'b1, '{ST_DONE,   6'd22, 7'd23}}
    };

    sorted_key_table #(
        .CAPACITY    (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .key         (key),
        .done        (done),
        .status      (status),
        .position    (position),
        .entry_total (entry_total)
    );

    always #5 clk = ~clk;

    // Predictor: applies one request to the held keys and returns the word the block
    // should answer with. Inserts go in front of the first key that is not smaller,
    // so a new duplicate precedes the keys equal to it. Finds and deletes work on the
    // first equal key.
    function automatic table_word_t apply_request(input logic [MODE_W-1:0] op,
                                                  input logic signed [KEY_W-1:0] k);
        int          slot;
        table_word_t w;
        w.status   = ST_ABSENT;
        w.position = '0;
        slot       = 0;
        case (op)
            MODE_INSERT:
            begin
                if (held_keys.size() >= CAPACITY)
                begin
                    w.status = ST_FULL;
                end
                else
                begin
                    while (slot < held_keys.size() && held_keys[slot] < k)
                        slot++;
                    held_keys.insert(slot, k);
                    w.status   = ST_DONE;
                    w.position = POS_W'(slot);
                end
            end
            MODE_FIND, MODE_DELETE:
            begin
                while (slot < held_keys.size() && held_keys[slot] != k)
                    slot++;
                if (slot < held_keys.size())
                begin
                    w.status   = ST_DONE;
                    w.position = POS_W'(slot);
                    if (op == MODE_DELETE)
                        held_keys.delete(slot);
                end
            end
            default:
            begin
            end
        endcase
        w.entry_total = TOTAL_W'(held_keys.size());
        return w;
    endfunction

    // Draws a key. For inserts, two draws in five come from a narrow band around zero so
    // that duplicates and hits are common; some hit the ends of the range, the rest are
    // full-width. Lookups prefer a key that is already stored so they mostly succeed.
    function automatic logic signed [KEY_W-1:0] pick_key(input bit prefer_stored);
        int                      r;
        logic signed [KEY_W-1:0] edge_keys [0:5];
        edge_keys = '{KEY_MIN, KEY_MIN + 1, -32'sd1, 32'sd0, KEY_MAX - 1, KEY_MAX};
        r = $urandom_range(99);
        if (prefer_stored && held_keys.size() != 0 && r < 55)
            return held_keys[$urandom_range(held_keys.size() - 1)];
        if (r < 40)
            return KEY_W'(int'($urandom_range(12)) - 6);
        if (r < 55)
            return edge_keys[$urandom_range(5)];
        return $urandom;
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input int ins_pct, input int find_pct,
                                                    input int del_pct);
        int r;
        r = $urandom_range(99);
        if (r < ins_pct)
            return MODE_INSERT;
        if (r < ins_pct + find_pct)
            return MODE_FIND;
        if (r < ins_pct + find_pct + del_pct)
            return MODE_DELETE;
        return MODE_UNUSED;
    endfunction

    // Presents one request word and returns at the edge where the block takes it.
    // start stays high on return, so a request that follows at once keeps it high.
    task automatic issue(input logic [MODE_W-1:0] op, input logic signed [KEY_W-1:0] k,
                         input bit typed, input table_word_t word);
        start       <= 1'b1;
        mode        <= op;
        key         <= k;
        typed_valid <= typed;
        typed_word  <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // After an accepted word the sender idles about a third of the time, mostly for a
    // few cycles and now and then for a longer gap that can outlast a whole scan of the
    // table. The payload carries junk while start is low.
    task automatic idle_gap();
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(99) < 33)
            gap = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(4, 1);
        if (gap > 0)
        begin
            start       <= 1'b0;
            mode        <= MODE_W'($urandom);
            key         <= $urandom;
            typed_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every expected word has come back. The first edge
    // lets the checker record the word that was accepted last.
    task automatic wait_for_results();
        start       <= 1'b0;
        typed_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int items, input int ins_pct, input int find_pct,
                                input int del_pct);
        logic [MODE_W-1:0] op;
        for (int n = 0; n < items; n++)
        begin
            op = pick_mode(ins_pct, find_pct, del_pct);
            issue(op, pick_key(op != MODE_INSERT), 1'b0, '0);
            idle_gap();
        end
    endtask

    // Checker: every result word is compared with the oldest expectation, then an
    // accepted request word is run through the predictor. Values are read at the
    // rising edge, before anything driven at that edge takes effect.
    always @(posedge clk)
    begin
        table_word_t want;
        table_word_t next_word;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d position %0d total %0d",
                           status, position, entry_total);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, position);
                        fail_count++;
                    end
                    if (entry_total !== want.entry_total)
                    begin
                        $error("entry_total: expected %0d, got %0d",
                               want.entry_total, entry_total);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                next_word = apply_request(mode, key);
                if (typed_valid)
                    next_word = typed_word;
                expected_words.push_back(next_word);
            end
        end
        if (done || (rst_n && start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog: ends the run if neither side moves a word for too long.
    initial
    begin
        @(posedge clk);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: each row is sent as many times as its repeat count says.
        foreach (directed_rows[i])
        begin
            for (int r = 0; r < directed_rows[i].reps; r++)
            begin
                issue(directed_rows[i].op, directed_rows[i].k,
                      directed_rows[i].typed, directed_rows[i].word);
                idle_gap();
            end
        end
        wait_for_results();

        // Mostly inserts: the table fills up and then refuses inserts for a while.
        random_phase(120, 70, 15, 10);
        wait_for_results();

        // Back-to-back mixed traffic with no idling on the sender side.
        idling_on = 1'b0;
        random_phase(160, 35, 35, 25);
        idling_on = 1'b1;
        wait_for_results();

        // Mostly deletes: the table drains and deletes start to miss.
        random_phase(120, 20, 15, 60);
        wait_for_results();

        // Mixed traffic again with idling, starting from a near-empty table.
        random_phase(125, 40, 30, 25);

        wait_for_results();
        repeat (CAPACITY + 4) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
